// ----- rtl/udpdc_pkg.sv -----
package udpdc_pkg;

  // Width of the configuration register index on the write channel.
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IPV4_PREFIX = 8'd0,
    CFG_IPV4_MASK   = 8'd1,
    CFG_IPV6_TOP16  = 8'd2,
    CFG_UDP_PORT    = 8'd3
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [31:0] IPV4_PREFIX_RST = 32'hC612_0000;
  localparam logic [31:0] IPV4_MASK_RST   = 32'hFFFF_FF00;
  localparam logic [15:0] IPV6_TOP16_RST  = 16'hFD00;
  localparam logic [15:0] UDP_PORT_RST    = 16'd1234;

  // EtherType and protocol codes.
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETH_TYPE_QINQ = 16'h88A8;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  // Frame offsets.
  localparam int unsigned OffW = 7;
  localparam logic [OffW-1:0] OFF_MAX       = 7'd127;
  localparam logic [OffW-1:0] OFF_TYPE_HI   = 7'd12;
  localparam logic [OffW-1:0] OFF_TYPE_LO   = 7'd13;
  localparam logic [OffW-1:0] OFF_TAG_HI    = 7'd16;
  localparam logic [OffW-1:0] OFF_TAG_LO    = 7'd17;
  localparam logic [OffW-1:0] BASE_UNTAGGED = 7'd14;
  localparam logic [OffW-1:0] BASE_TAGGED   = 7'd18;

  // Offsets relative to the start of the IP header.
  localparam logic [OffW-1:0] V4_REL_PROTO    = 7'd9;
  localparam logic [OffW-1:0] V4_REL_ADDR_LO  = 7'd16;
  localparam logic [OffW-1:0] V4_REL_ADDR_HI  = 7'd19;
  localparam logic [OffW-1:0] V4_REL_PORT_HI  = 7'd22;
  localparam logic [OffW-1:0] V4_REL_PORT_LO  = 7'd23;
  localparam logic [OffW-1:0] V6_REL_NEXT     = 7'd6;
  localparam logic [OffW-1:0] V6_REL_ADDR_HI  = 7'd24;
  localparam logic [OffW-1:0] V6_REL_ADDR_LO  = 7'd25;
  localparam logic [OffW-1:0] V6_REL_PORT_HI  = 7'd42;
  localparam logic [OffW-1:0] V6_REL_PORT_LO  = 7'd43;

  // Minimum final-byte offset, relative to the start of the IP header, for a frame
  // to hold the UDP header (IP and UDP header length minus one).
  localparam logic [OffW-1:0] V4_LAST_MIN = 7'd27;
  localparam logic [OffW-1:0] V6_LAST_MIN = 7'd47;

endpackage

// ----- rtl/udp_packet_drop_classifier_top.sv -----
// Verdict path: the final frame byte sits in the input register, and its verdict is
// registered in the result register when that byte advances.
// Throughput: one frame byte per cycle; a final byte waits only while an earlier
// verdict is still held in the result register.
// Reset: asynchronous, active low; clears the parse state, the pipeline valid flags and
// restores the configuration registers to their default values.
module udp_packet_drop_classifier_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Frame byte channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    frame_byte_i,
  input  logic                          frame_end_i,
  // Verdict channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          drop_o,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [udpdc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import udpdc_pkg::*;

  // Configuration registers.
  logic [31:0] ipv4_prefix_q, ipv4_mask_q;
  logic [15:0] ipv6_top16_q, udp_port_q;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Parse state.
  logic [OffW-1:0] offset_q, offset_d;
  logic [15:0]     ether_kind_q, ether_kind_d;
  logic            tagged_q, tagged_d;
  logic            is_udp_q, is_udp_d;
  logic [31:0]     addr_q, addr_d;
  logic [15:0]     port_q, port_d;

  // Result register.
  logic out_valid_q;
  logic drop_q, drop_d;

  // Handshake control.
  logic advance;
  logic in_accept;
  logic out_free;

  assign cfg_ready_o = 1'b1;

  // The output slot is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  // A middle byte never needs the output slot; a final byte waits for it.
  assign advance    = in_valid_q && (!in_end_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign drop_o      = drop_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_prefix_q <= IPV4_PREFIX_RST;
      ipv4_mask_q   <= IPV4_MASK_RST;
      ipv6_top16_q  <= IPV6_TOP16_RST;
      udp_port_q    <= UDP_PORT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IPV4_PREFIX: ipv4_prefix_q <= cfg_data_i;
        CFG_IPV4_MASK:   ipv4_mask_q   <= cfg_data_i;
        CFG_IPV6_TOP16:  ipv6_top16_q  <= cfg_data_i[15:0];
        CFG_UDP_PORT:    udp_port_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is empty or moving on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= frame_byte_i;
      in_end_q  <= frame_end_i;
    end
  end

  // Header parse for one byte and the verdict on the final byte.
  always_comb begin
    logic [OffW-1:0] base;
    logic [OffW-1:0] base_new;
    logic [OffW-1:0] rel;
    logic            v4;
    logic            v6;
    logic            in_ip;
    logic            port_ok;

    base  = tagged_q ? BASE_TAGGED : BASE_UNTAGGED;
    v4    = (ether_kind_q == ETH_TYPE_IPV4);
    v6    = (ether_kind_q == ETH_TYPE_IPV6);
    rel   = offset_q - base;
    in_ip = (offset_q >= base) && (v4 || v6);

    ether_kind_d = ether_kind_q;
    tagged_d     = tagged_q;
    is_udp_d     = is_udp_q;
    addr_d       = addr_q;
    port_d       = port_q;

    // EtherType, taken again after a tag.
    if (offset_q == OFF_TYPE_HI || offset_q == OFF_TYPE_LO ||
        (tagged_q && (offset_q == OFF_TAG_HI || offset_q == OFF_TAG_LO))) begin
      ether_kind_d = {ether_kind_q[7:0], in_byte_q};
    end
    if (offset_q == OFF_TYPE_LO &&
        (ether_kind_d == ETH_TYPE_VLAN || ether_kind_d == ETH_TYPE_QINQ)) begin
      tagged_d = 1'b1;
    end

    // Protocol, destination address and UDP port fields.
    if (in_ip && v4) begin
      if (rel == V4_REL_PROTO) is_udp_d = (in_byte_q == PROTO_UDP);
      if (rel >= V4_REL_ADDR_LO && rel <= V4_REL_ADDR_HI) begin
        addr_d = {addr_q[23:0], in_byte_q};
      end
      if (rel == V4_REL_PORT_HI || rel == V4_REL_PORT_LO) begin
        port_d = {port_q[7:0], in_byte_q};
      end
    end else if (in_ip) begin
      if (rel == V6_REL_NEXT) is_udp_d = (in_byte_q == PROTO_UDP);
      if (rel == V6_REL_ADDR_HI || rel == V6_REL_ADDR_LO) begin
        addr_d = {16'd0, addr_q[7:0], in_byte_q};
      end
      if (rel == V6_REL_PORT_HI || rel == V6_REL_PORT_LO) begin
        port_d = {port_q[7:0], in_byte_q};
      end
    end

    // Verdict from the state including this byte.
    base_new = tagged_d ? BASE_TAGGED : BASE_UNTAGGED;
    port_ok  = (port_d == udp_port_q);
    drop_d   = 1'b0;
    if (ether_kind_d == ETH_TYPE_IPV4) begin
      drop_d = (offset_q >= base_new + V4_LAST_MIN) && is_udp_d && port_ok &&
               ((addr_d & ipv4_mask_q) == ipv4_prefix_q);
    end else if (ether_kind_d == ETH_TYPE_IPV6) begin
      drop_d = (offset_q >= base_new + V6_LAST_MIN) && is_udp_d && port_ok &&
               (addr_d[15:0] == ipv6_top16_q);
    end

    // Byte offset saturates; the final byte starts a fresh frame.
    offset_d = (offset_q < OFF_MAX) ? offset_q + 7'd1 : offset_q;
    if (in_end_q) begin
      offset_d     = '0;
      ether_kind_d = '0;
      tagged_d     = 1'b0;
      is_udp_d     = 1'b0;
      addr_d       = '0;
      port_d       = '0;
    end
  end

  // Parse state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      ether_kind_q <= '0;
      tagged_q     <= 1'b0;
      is_udp_q     <= 1'b0;
      addr_q       <= '0;
      port_q       <= '0;
    end else if (advance) begin
      offset_q     <= offset_d;
      ether_kind_q <= ether_kind_d;
      tagged_q     <= tagged_d;
      is_udp_q     <= is_udp_d;
      addr_q       <= addr_d;
      port_q       <= port_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_end_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_end_q) begin
      drop_q <= drop_d;
    end
  end

endmodule

// ----- dv/udpdc_verdict_checker.sv -----
module udpdc_verdict_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Frame byte channel, as seen at the block's pins
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    frame_byte_i,
  input  logic                          frame_end_i,
  // Verdict channel
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          drop_i,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [udpdc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  // Status towards the testbench top
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            verdicts_o,
  output int                            drops_o
);

  import udpdc_pkg::*;

  // Shadow copy of the configuration registers.
  logic [31:0] prefix_q;
  logic [31:0] mask_q;
  logic [15:0] top16_q;
  logic [15:0] port_cfg_q;

  // Per-frame parse state, mirrored from the block's behaviour.
  logic [OffW-1:0] off_q;
  logic [15:0]     etype_q;
  logic            vlan_seen_q;
  logic            udp_q;
  logic [31:0]     addr_q;
  logic [15:0]     port_q;

  // Verdicts predicted but not yet seen on the output channel.
  logic verdict_q [$];
  logic want_drop;

  int fail_cnt    = 0;
  int pending_cnt = 0;
  int verdict_cnt = 0;
  int drop_cnt    = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;
  assign verdicts_o   = verdict_cnt;
  assign drops_o      = drop_cnt;

  task automatic clear_frame_state();
    off_q       = '0;
    etype_q     = '0;
    vlan_seen_q = 1'b0;
    udp_q       = 1'b0;
    addr_q      = '0;
    port_q      = '0;
  endtask

  task automatic note_mismatch(input string what, input logic want, input logic got);
    if (fail_cnt < 10) begin
      $display("[%0t] verdict mismatch: %s, expected drop=%0b, got drop=%0b",
               $time, what, want, got);
    end
    fail_cnt++;
  endtask

  // Advance the parse by one accepted byte; on the final byte the verdict is queued.
  task automatic parse_frame_byte(input logic [7:0] b, input logic last);
    int unsigned off;
    int unsigned base;
    int unsigned rel;
    logic        is_v4;
    logic        is_v6;
    logic        hit;
    off   = 32'(off_q);
    base  = vlan_seen_q ? 32'(BASE_TAGGED) : 32'(BASE_UNTAGGED);
    is_v4 = (etype_q == ETH_TYPE_IPV4);
    is_v6 = (etype_q == ETH_TYPE_IPV6);

    // EtherType, and the inner one after a single tag.
    if (off == OFF_TYPE_HI || off == OFF_TYPE_LO ||
        (vlan_seen_q && (off == OFF_TAG_HI || off == OFF_TAG_LO))) begin
      etype_q = {etype_q[7:0], b};
    end
    if (off == OFF_TYPE_LO && (etype_q == ETH_TYPE_VLAN || etype_q == ETH_TYPE_QINQ)) begin
      vlan_seen_q = 1'b1;
    end

    // IP and UDP header fields, relative to the start of the IP header.
    if (off >= base && (is_v4 || is_v6)) begin
      rel = off - base;
      if (is_v4) begin
        if (rel == V4_REL_PROTO) udp_q = (b == PROTO_UDP);
        if (rel >= V4_REL_ADDR_LO && rel <= V4_REL_ADDR_HI) addr_q = {addr_q[23:0], b};
        if (rel == V4_REL_PORT_HI || rel == V4_REL_PORT_LO) port_q = {port_q[7:0], b};
      end else begin
        if (rel == V6_REL_NEXT) udp_q = (b == PROTO_UDP);
        if (rel == V6_REL_ADDR_HI || rel == V6_REL_ADDR_LO) begin
          addr_q = {16'h0000, addr_q[7:0], b};
        end
        if (rel == V6_REL_PORT_HI || rel == V6_REL_PORT_LO) port_q = {port_q[7:0], b};
      end
    end

    if (!last) begin
      if (off_q != OFF_MAX) off_q = off_q + 1'b1;
    end else begin
      base = vlan_seen_q ? 32'(BASE_TAGGED) : 32'(BASE_UNTAGGED);
      hit  = 1'b0;
      if (etype_q == ETH_TYPE_IPV4) begin
        hit = (off >= base + V4_LAST_MIN) && udp_q &&
              ((addr_q & mask_q) == prefix_q) && (port_q == port_cfg_q);
      end else if (etype_q == ETH_TYPE_IPV6) begin
        hit = (off >= base + V6_LAST_MIN) && udp_q &&
              (addr_q[15:0] == top16_q) && (port_q == port_cfg_q);
      end
      verdict_q.push_back(hit);
      clear_frame_state();
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   = IPV4_PREFIX_RST;
      mask_q     = IPV4_MASK_RST;
      top16_q    = IPV6_TOP16_RST;
      port_cfg_q = UDP_PORT_RST;
      clear_frame_state();
      verdict_q.delete();
      pending_cnt <= 0;
    end else begin
      // Register writes; an unknown index leaves everything as it was.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IPV4_PREFIX: prefix_q = cfg_data_i;
          CFG_IPV4_MASK:   mask_q = cfg_data_i;
          CFG_IPV6_TOP16:  top16_q = cfg_data_i[15:0];
          CFG_UDP_PORT:    port_cfg_q = cfg_data_i[15:0];
          default: ;
        endcase
      end

      // Compare each verdict transaction with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        verdict_cnt++;
        if (drop_i) drop_cnt++;
        if (verdict_q.size() == 0) begin
          note_mismatch("verdict with no frame outstanding", 1'bx, drop_i);
        end else begin
          want_drop = verdict_q.pop_front();
          if (want_drop !== drop_i) note_mismatch("wrong verdict", want_drop, drop_i);
        end
      end

      if (in_valid_i && !in_stall_i) parse_frame_byte(frame_byte_i, frame_end_i);

      pending_cnt <= verdict_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

  import udpdc_pkg::*;

  typedef enum int {TAG_NONE, TAG_VLAN, TAG_QINQ, TAG_DOUBLE} tag_kind_e;
  typedef enum int {L3_IPV4, L3_IPV6, L3_OTHER} l3_kind_e;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic [7:0]         frame_byte = 8'h00;
  logic               frame_end  = 1'b0;
  logic               out_stall  = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [31:0]        cfg_data   = '0;

  logic in_stall;
  logic out_valid;
  logic drop;
  logic cfg_ready;

  int fail_count;
  int pending;
  int verdicts;
  int drops;

  // Register values currently programmed, used to build matching headers.
  logic [31:0] cur_prefix = IPV4_PREFIX_RST;
  logic [31:0] cur_mask   = IPV4_MASK_RST;
  logic [15:0] cur_top16  = IPV6_TOP16_RST;
  logic [15:0] cur_port   = UDP_PORT_RST;

  // Frame under construction.
  logic [7:0] fbuf [0:255];
  int         flen;

  bit tx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;
  int bytes_sent  = 0;
  int frames_sent = 0;

  always #2 clk = ~clk;

  udp_packet_drop_classifier_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .frame_byte_i (frame_byte),
    .frame_end_i  (frame_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .drop_o       (drop),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  udpdc_verdict_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .frame_byte_i (frame_byte),
    .frame_end_i  (frame_end),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .drop_i       (drop),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .verdicts_o   (verdicts),
    .drops_o      (drops)
  );

  // Offer one byte and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    frame_end  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic ship_frame(input bit quiet_run);
    int i;
    tx_quiet = quiet_run || ($urandom_range(0, 3) == 0);
    for (i = 0; i < flen; i++) send_byte(fbuf[i], i == flen - 1);
    frames_sent++;
  endtask

  function automatic void fill_random();
    int i;
    for (i = 0; i < 256; i++) fbuf[i] = 8'($urandom_range(0, 255));
  endfunction

  function automatic void put16(input int at, input logic [15:0] v);
    fbuf[at]     = v[15:8];
    fbuf[at + 1] = v[7:0];
  endfunction

  // Lay out an Ethernet frame; each *_ok flag makes that field match the filter.
  task automatic build_frame(input tag_kind_e tk, input l3_kind_e l3, input bit proto_ok,
                             input bit addr_ok, input bit port_ok, input int extra);
    int          ip;
    int          min_len;
    logic [15:0] etype;
    logic [31:0] addr;
    fill_random();
    case (l3)
      L3_IPV4: etype = ETH_TYPE_IPV4;
      L3_IPV6: etype = ETH_TYPE_IPV6;
      default: etype = 16'($urandom_range(0, 65535));
    endcase
    case (tk)
      TAG_NONE: begin
        put16(int'(OFF_TYPE_HI), etype);
        ip = int'(BASE_UNTAGGED);
      end
      TAG_VLAN: begin
        put16(int'(OFF_TYPE_HI), ETH_TYPE_VLAN);
        put16(int'(OFF_TAG_HI), etype);
        ip = int'(BASE_TAGGED);
      end
      TAG_QINQ: begin
        put16(int'(OFF_TYPE_HI), ETH_TYPE_QINQ);
        put16(int'(OFF_TAG_HI), etype);
        ip = int'(BASE_TAGGED);
      end
      default: begin
        // Outer and inner tag; the block only skips the outer one.
        put16(int'(OFF_TYPE_HI), ETH_TYPE_QINQ);
        put16(int'(OFF_TAG_HI), ETH_TYPE_VLAN);
        put16(int'(BASE_TAGGED) + 2, etype);
        ip = int'(BASE_TAGGED) + 4;
      end
    endcase
    if (l3 == L3_IPV6) begin
      if (proto_ok) fbuf[ip + V6_REL_NEXT] = PROTO_UDP;
      if (addr_ok) put16(ip + V6_REL_ADDR_HI, cur_top16);
      if (port_ok) put16(ip + V6_REL_PORT_HI, cur_port);
      min_len = ip + V6_LAST_MIN + 1;
    end else begin
      if (l3 == L3_IPV4) begin
        if (proto_ok) fbuf[ip + V4_REL_PROTO] = PROTO_UDP;
        addr = $urandom;
        if (addr_ok) addr = (cur_prefix & cur_mask) | (addr & ~cur_mask);
        put16(ip + V4_REL_ADDR_LO, addr[31:16]);
        put16(ip + V4_REL_ADDR_LO + 2, addr[15:0]);
        if (port_ok) put16(ip + V4_REL_PORT_HI, cur_port);
      end
      min_len = ip + V4_LAST_MIN + 1;
    end
    flen = min_len + extra;
    if (flen < 1) flen = 1;
    if (flen > 256) flen = 256;
  endtask

  // Mostly well-formed IP/UDP frames with random content, some noise and short frames.
  task automatic random_frame();
    int        r;
    int        extra;
    tag_kind_e tk;
    l3_kind_e  l3;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      fill_random();
      flen = $urandom_range(1, 24);
    end else begin
      r  = $urandom_range(0, 99);
      tk = (r < 55) ? TAG_NONE : (r < 75) ? TAG_VLAN : (r < 93) ? TAG_QINQ : TAG_DOUBLE;
      r  = $urandom_range(0, 99);
      l3 = (r < 45) ? L3_IPV4 : (r < 88) ? L3_IPV6 : L3_OTHER;
      r  = $urandom_range(0, 99);
      if (r < 70) extra = $urandom_range(0, 6);
      else if (r < 85) extra = -int'($urandom_range(1, 30));
      else if (r < 96) extra = $urandom_range(7, 40);
      else extra = $urandom_range(80, 200);
      build_frame(tk, l3, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85,
                  $urandom_range(0, 99) < 85, extra);
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program all four registers, plus one write to an unused index.
  task automatic program_regs(input logic [31:0] p, input logic [31:0] m,
                              input logic [15:0] t, input logic [15:0] prt,
                              input logic [CfgIdxW-1:0] junk_idx);
    logic [31:0] r;
    r = $urandom;
    cfg_write(CFG_IPV4_PREFIX, p);
    cfg_write(CFG_IPV4_MASK, m);
    cfg_write(CFG_IPV6_TOP16, {r[31:16], t});
    cfg_write(CFG_UDP_PORT, {r[15:0], prt});
    cfg_write(junk_idx, $urandom);
    cfg_valid  <= 1'b0;
    cur_prefix = p;
    cur_mask   = m;
    cur_top16  = t;
    cur_port   = prt;
  endtask

  // Stop sending and wait until every verdict has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Verdict side: a random stall before each transaction, quiet stretches, and one long hold.
  initial begin : verdict_receiver
    int gap;
    bit rx_quiet;
    rx_quiet = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        gap = 300;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 17);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : run_limit
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    int          k;
    logic [31:0] rp;
    logic [31:0] rm;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames against the reset register values.
    fill_random();
    fbuf[0] = 8'h00;
    flen    = 1;
    ship_frame(1'b0);
    fbuf[0] = 8'hFF;
    ship_frame(1'b0);
    build_frame(TAG_NONE, L3_IPV4, 1, 1, 1, 0);   ship_frame(1'b0);
    build_frame(TAG_NONE, L3_IPV4, 1, 1, 1, -1);  ship_frame(1'b0);
    build_frame(TAG_QINQ, L3_IPV6, 1, 1, 1, 0);   ship_frame(1'b0);
    build_frame(TAG_DOUBLE, L3_IPV4, 1, 1, 1, 0); ship_frame(1'b0);
    // Long enough for the byte offset to sit at its ceiling for a few bytes.
    build_frame(TAG_NONE, L3_IPV4, 1, 1, 1, 88);  ship_frame(1'b0);

    // One random frame under each of a sequence of register settings, plus short frames under the third.
    for (phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: program_regs(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 8'hFF);
        1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                        CfgIdxW'($urandom_range(4, 255)));
        default: begin
          rm = 32'hFFFF_FFFF << $urandom_range(0, 32);
          rp = $urandom;
          if ($urandom_range(0, 3) != 0) rp = rp & rm;
          program_regs(rp, rm, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), CfgIdxW'($urandom_range(4, 255)));
        end
      endcase

      // Back-pressure: the receiver holds off while short frames keep arriving.
      if (phase == 2) begin
        rx_hold_req = 1'b1;
        for (k = 0; k < 24; k++) begin
          fill_random();
          flen = $urandom_range(1, 3);
          ship_frame(1'b1);
        end
        settle();
      end

      random_frame();
      ship_frame(1'b0);
    end

    settle();
    if (pending != 0) $display("%0d predicted verdicts never arrived", pending);
    $display("Sent %0d frames (%0d bytes) under reset and five other register settings.",
             frames_sent, bytes_sent);
    $display("Checked %0d verdicts, %0d of them drops; %0d mismatches.",
             verdicts, drops, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- udp_packet_drop_classifier_top.f -----
rtl/udpdc_pkg.sv
rtl/udp_packet_drop_classifier_top.sv
dv/udpdc_verdict_checker.sv
dv/tb_top.sv
